@@ src/prht_pkg.sv @@
// prht_pkg: shared types and codes for the priority rectangle hit table
// no dependencies
package prht_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_VISIT = 1'b1;

    typedef struct packed {
        logic [7:0]  handle;
        logic [15:0] prio;
    } t_order;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0]        w;
        logic [15:0]        h;
    } t_rect;

    typedef struct packed {
        logic       kind;
        logic [7:0] elem;
        logic       hit;
        t_status    status;
        logic       last;
    } t_result;

    // closed interval test on one axis: 2c - s <= 2p <= 2c + s
    function automatic logic axis_in(logic signed [15:0] p, logic signed [15:0] c,
                                     logic [15:0] s);
        logic signed [18:0] p2;
        logic signed [18:0] c2;
        logic signed [18:0] sz;
        p2 = 19'(signed'({p, 1'b0}));
        c2 = 19'(signed'({c, 1'b0}));
        sz = signed'({3'b000, s});
        return (p2 >= c2 - sz) && (p2 <= c2 + sz);
    endfunction

endpackage

@@ src/prht_store.sv @@
// prht_store: entry memory, order and rectangle fields in one synchronous ram
// depends on prht_pkg
module prht_store
    import prht_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_raddr,
    output t_order        o_rorder,
    output t_rect         o_rrect,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_order        i_worder,
    input  t_rect         i_wrect
);

    logic [$bits(t_order)+$bits(t_rect)-1:0] r_mem [DEPTH];
    logic [$bits(t_order)+$bits(t_rect)-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_worder, i_wrect};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign {o_rorder, o_rrect} = r_rdata;

endmodule

@@ src/priority_rect_hit_table_unit.sv @@
// priority_rect_hit_table_unit: top level, sequencer around the entry memory
// depends on prht_pkg and prht_store
//
// usage
//   input channel: i_valid / o_ready with one command per transfer
//     add    inserts an entry after all entries of equal or lower priority
//     update rewrites the rectangle of every entry with the given handle
//     test   scans entries from the front, one result per visited entry,
//            stopping after the first entry whose closed rectangle holds the point
//   output channel: o_valid / i_ready, one result per transfer, last marks the end
// sequencing
//   one item at a time through the memory with one read and one write port (read
//   issue, then data back and write or emit)
//   add: search through S_SRD and S_SCHK per entry compared, shift through S_MRD and
//   S_MWR per moved entry, then S_INS writes the new entry and S_OUT hands over the
//   acknowledgement; update: S_MRD and S_MWR per stored entry; test: S_MRD, S_MWR and
//   S_OUT per visited entry
// reset
//   entry count clears to zero, memory contents are left as they are
// stalls
//   a result sits in an output register; the scan waits while it is not taken
module priority_rect_hit_table_unit
    import prht_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_element_id,
    input  logic [15:0]        i_priority_req,
    input  logic signed [15:0] i_rect_x,
    input  logic signed [15:0] i_rect_y,
    input  logic [15:0]        i_rect_width,
    input  logic [15:0]        i_rect_height,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_result_kind,
    output logic [7:0]         o_hit_element,
    output logic               o_hit,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRD   = 7'b0000010, // add: search read issued
        S_SCHK  = 7'b0000100, // add: compare priority
        S_MRD   = 7'b0001000, // add shift / update / test: read issued
        S_MWR   = 7'b0010000, // data back: act on entry
        S_INS   = 7'b0100000, // add: write new entry
        S_OUT   = 7'b1000000  // wait for result to drain
    } t_state;

    t_state           r_state, n_state;
    t_cmd             r_cmd;
    t_order           r_new_ord;
    t_rect            r_new_rect;
    logic signed [15:0] r_px, r_py;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;     // scan index or shift source + 1
    logic [CW-1:0]    r_pos, n_pos;     // insert position
    logic             r_found, n_found;
    t_result          r_res, n_res;
    logic             r_ovalid, n_ovalid;
    logic             n_done;           // current result ends the item

    logic [AW-1:0] w_raddr;
    t_order        w_rord;
    t_rect         w_rrect;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_order        w_word;
    t_rect         w_wrect;
    logic          w_out_free;
    logic          w_hit;

    prht_store #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
        .i_clk    (i_clk),
        .i_raddr  (w_raddr),
        .o_rorder (w_rord),
        .o_rrect  (w_rrect),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_worder (w_word),
        .i_wrect  (w_wrect)
    );

    assign o_ready    = (r_state == S_IDLE) && !r_ovalid;
    assign w_out_free = !r_ovalid || i_ready;
    assign w_hit      = axis_in(r_px, w_rrect.cx, w_rrect.w)
                     && axis_in(r_py, w_rrect.cy, w_rrect.h);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_found  = r_found;
        n_res    = r_res;
        n_done   = 1'b0;
        n_ovalid = r_ovalid && !i_ready;
        w_raddr  = r_idx[AW-1:0];
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_word   = w_rord;
        w_wrect  = w_rrect;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    priority case (t_cmd'(i_cmd))
                        CMD_ADD: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_res    = '{KIND_ACK, i_element_id, 1'b0, ST_FULL, 1'b1};
                                n_ovalid = 1'b1;
                            end else if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_INS;
                            end else begin
                                n_state = S_SRD;
                            end
                        end
                        CMD_UPDATE: begin
                            if (r_count == '0) begin
                                n_res    = '{KIND_ACK, i_element_id, 1'b0, ST_UNKNOWN,
                                             1'b1};
                                n_ovalid = 1'b1;
                            end else begin
                                n_state = S_MRD;
                            end
                        end
                        CMD_TEST: begin
                            if (r_count != '0) begin
                                n_state = S_MRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SRD: n_state = S_SCHK;
            S_SCHK: begin
                // stop at first entry with a strictly higher priority, or at the last entry
                if (w_rord.prio > r_new_ord.prio || r_idx + 1'b1 == r_count) begin
                    n_pos = (w_rord.prio > r_new_ord.prio) ? r_idx : r_count;
                    if (n_pos == r_count) begin
                        n_state = S_INS;
                    end else begin
                        n_idx   = r_count;
                        n_state = S_MRD;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_MRD: begin
                if (r_cmd == CMD_ADD) begin
                    w_raddr = AW'(r_idx - 1'b1);
                end
                n_state = S_MWR;
            end
            S_MWR: begin
                priority case (r_cmd)
                    CMD_ADD: begin
                        w_we    = 1'b1;
                        w_waddr = r_idx[AW-1:0];
                        n_idx   = r_idx - 1'b1;
                        n_state = (n_idx == r_pos) ? S_INS : S_MRD;
                    end
                    CMD_UPDATE: begin
                        if (w_rord.handle == r_new_ord.handle) begin
                            w_we    = 1'b1;
                            w_wrect = r_new_rect;
                            n_found = 1'b1;
                        end
                        n_idx = r_idx + 1'b1;
                        if (n_idx == r_count) begin
                            n_res = '{KIND_ACK, r_new_ord.handle, 1'b0,
                                      (w_rord.handle == r_new_ord.handle || r_found)
                                      ? ST_OK : ST_UNKNOWN, 1'b1};
                            n_state = S_OUT;
                        end else begin
                            n_state = S_MRD;
                        end
                    end
                    default: begin
                        // previous result must leave the output register first
                        if (w_out_free) begin
                            n_done  = w_hit || (r_idx + 1'b1 == r_count);
                            n_res   = '{KIND_VISIT, w_rord.handle, w_hit, ST_OK, n_done};
                            n_idx   = r_idx + 1'b1;
                            n_state = S_OUT;
                        end
                    end
                endcase
            end
            S_INS: begin
                w_we     = 1'b1;
                w_waddr  = r_pos[AW-1:0];
                w_word   = r_new_ord;
                w_wrect  = r_new_rect;
                n_count  = r_count + 1'b1;
                n_res    = '{KIND_ACK, r_new_ord.handle, 1'b0, ST_OK, 1'b1};
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = (r_cmd == CMD_TEST && !r_res.last) ? S_MRD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_res   <= n_res;
        if (i_valid && o_ready) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_new_ord  <= '{i_element_id, i_priority_req};
            r_new_rect <= '{i_rect_x, i_rect_y, i_rect_width, i_rect_height};
            r_px       <= i_point_x;
            r_py       <= i_point_y;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_result_kind = r_res.kind;
    assign o_hit_element = r_res.elem;
    assign o_hit         = r_res.hit;
    assign o_status      = r_res.status;
    assign o_last        = r_res.last;

endmodule

@@ src/prht_checker.sv @@
// prht_checker: port level checks for the hit table
// depends on prht_pkg; bound to priority_rect_hit_table_unit
module prht_checker
    import prht_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_result_kind,
    input logic       o_hit,
    input logic [1:0] o_status,
    input logic       o_last
);

    // a stalled result stays valid and keeps its last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_last))
        else $error("stalled result changed");

    // a hit always closes the scan
    a_hit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_last)
        else $error("hit without last");

    // acknowledgements are single results with no hit
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_ACK |-> o_last && !o_hit)
        else $error("bad acknowledgement");

    // test results carry status ok
    a_test_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_VISIT |-> o_status == ST_OK)
        else $error("test result with status");

endmodule

bind priority_rect_hit_table_unit prht_checker u_prht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_kind (o_result_kind),
    .o_hit         (o_hit),
    .o_status      (o_status),
    .o_last        (o_last)
);
